### sv/whap_pkg.sv
// Package: constants, record codes and types for the frame header parser.
package whap_pkg;

   localparam int unsigned MaxFrameBytes = 4095;
   localparam int unsigned MaxStations   = 32;
   localparam int unsigned HdrBytes      = 20;
   localparam logic [11:0] StationBase   = 12'h034;
   localparam logic [11:0] AggFirst      = 12'd24;
   localparam logic [47:0] Magic         = 48'h01fe23dc45ba;

   typedef enum logic [2:0] {
      KIND_HEADER   = 3'd0,
      KIND_STATION  = 3'd1,
      KIND_SUBFRAME = 3'd2,
      KIND_TRAILING = 3'd3,
      KIND_TRUNC    = 3'd4
   } kind_type;

   typedef enum logic [1:0] {
      CLASS_BEACON  = 2'd0,
      CLASS_MGMT    = 2'd1,
      CLASS_DATA    = 2'd2,
      CLASS_UNKNOWN = 2'd3
   } class_type;

   typedef enum logic [2:0] {
      PH_HEADER  = 3'd0,
      PH_DECIDE  = 3'd1,
      PH_ST_WAIT = 3'd2,
      PH_ST_CAP  = 3'd3,
      PH_AG_LOW  = 3'd4,
      PH_AG_HIGH = 3'd5,
      PH_DONE    = 3'd6
   } phase_type;

   typedef struct packed {
      logic [7:0]  data_byte;
      logic        frame_start;
      logic [11:0] frame_length;
   } req_type;

   typedef struct packed {
      logic [2:0]  record_kind;
      logic [1:0]  packet_class;
      logic [7:0]  type_byte;
      logic [7:0]  mode_byte;
      logic        alt_header;
      logic [23:0] counter;
      logic [47:0] address;
      logic [23:0] timestamp;
      logic [31:0] ip_address;
      logic [11:0] item_index;
      logic [11:0] item_offset;
      logic [11:0] item_length;
   } rsp_type;

endpackage

### sv/whap_if.sv
// Interfaces: request and response channels with valid/ready handshake.
interface whap_req_if import whap_pkg::*; ();
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface whap_rsp_if import whap_pkg::*; ();
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

### sv/wireless_header_and_aggregate_parser_core.sv
// Top level: byte-serial frame header and aggregate payload parser.
//
// Usage: frame bytes enter on the req channel, one request per byte, with
// frame_start and frame_length on the first byte of each frame. Each byte
// gives zero or one record on the rsp channel: the header record on byte 19,
// station or subframe records inside the payload, a trailing-data record on
// the last byte, or a truncated record on the last byte of a short frame.
// Latency: a record appears in the output register the cycle after the byte
// that causes it is accepted. Throughput: one byte per cycle; the per-byte
// bookkeeping is a few short adds and compares between the parse registers.
// A byte is taken whenever the output register is empty or is being emptied
// in the same cycle, so a stalled receiver holds the pending record and stops
// the input only while that record waits.
// Reset (synchronous, active high) clears the parse phase, counters and the
// output valid; the header buffer holds no reset and is filled by each frame.
// Bytes outside a frame are dropped; a new frame_start drops the old frame.
module wireless_header_and_aggregate_parser_core import whap_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   whap_req_if.sink    req,
   whap_rsp_if.source  rsp
);
   logic [7:0]  hdr_ff [HdrBytes];
   logic [11:0] pos_ff, pos_in;
   logic [11:0] len_ff, len_in;
   phase_type   phase_ff, phase_in;
   logic [5:0]  st_cnt_ff, st_cnt_in;
   logic [11:0] sub_cnt_ff, sub_cnt_in;
   logic [11:0] nho_ff, nho_in;
   logic [7:0]  low_ff, low_in;
   logic [12:0] toff_ff, toff_in;
   logic [47:0] shift_ff, shift_in;
   logic        tval_ff, tval_in;
   logic        ovalid_ff, ovalid_in;
   rsp_type     odata_ff, odata_in;

   logic [7:0]  hdr_cur [HdrBytes];
   rsp_type     hdr_rec;
   logic        accept;
   logic [7:0]  b;
   logic        emit;
   rsp_type     rec;
   logic [11:0] flen;
   logic [11:0] pos, len_cur;
   logic [11:0] agg_len;
   logic signed [14:0] left, body, rem;
   logic [12:0] nxt;

   // take the last header byte straight from the input
   always_comb begin
      hdr_cur = hdr_ff;
      hdr_cur[HdrBytes - 1] = b;
   end

   whap_header_decode u_hdr (.hdr(hdr_cur), .rec(hdr_rec));

   assign req.ready = !ovalid_ff || rsp.ready;
   assign accept    = req.valid && req.ready;
   assign rsp.valid = ovalid_ff;
   assign rsp.data  = odata_ff;
   assign b         = req.data.data_byte;

   // advance the parse state for one accepted byte
   always_comb begin
      pos_in     = pos_ff;
      len_in     = len_ff;
      phase_in   = phase_ff;
      st_cnt_in  = st_cnt_ff;
      sub_cnt_in = sub_cnt_ff;
      nho_in     = nho_ff;
      low_in     = low_ff;
      toff_in    = toff_ff;
      shift_in   = shift_ff;
      tval_in    = tval_ff;
      emit       = 1'b0;
      rec        = '0;
      flen       = req.data.frame_length;
      agg_len    = {b[3:0], low_ff};
      left       = 15'(len_ff) - 15'(nho_ff);
      body       = left - 15'sd2;
      rem        = body - 15'(agg_len);
      nxt        = 13'(nho_ff) + 13'd2 + 13'(agg_len);
      pos        = pos_ff;
      len_cur    = len_ff;
      if (req.data.frame_start) begin
         if (flen == 12'd0) flen = 12'd1;
         len_cur  = flen;
         pos      = '0;
         phase_in = PH_HEADER;
         tval_in  = 1'b0;
         len_in   = flen;
         left     = 15'(flen) - 15'(nho_ff);
         body     = left - 15'sd2;
         rem      = body - 15'(agg_len);
      end
      pos_in = pos;
      if (pos < len_cur) begin
         pos_in = pos + 12'd1;
         unique case (req.data.frame_start ? PH_HEADER : phase_ff)
            PH_HEADER: begin
               if (pos == 12'(HdrBytes - 1)) begin
                  rec  = hdr_rec;
                  emit = 1'b1;
                  phase_in = (len_cur > 12'd26) ? PH_DECIDE : PH_DONE;
               end else if (pos == len_cur - 12'd1) begin
                  rec.record_kind = KIND_TRUNC;
                  rec.item_length = len_cur;
                  emit = 1'b1;
                  phase_in = PH_DONE;
               end
            end
            PH_DECIDE: begin
               if (b >= 8'h20) begin
                  st_cnt_in = '0;
                  toff_in   = 13'(StationBase);
                  tval_in   = 1'b1;
                  phase_in  = PH_ST_WAIT;
               end else begin
                  sub_cnt_in = '0;
                  nho_in     = AggFirst;
                  phase_in   = PH_AG_LOW;
               end
            end
            PH_ST_WAIT: begin
               if (13'(pos) == toff_ff) begin
                  if (st_cnt_ff < 6'(MaxStations) && 13'(len_cur) > toff_ff + 13'd6
                      && b == 8'h00) begin
                     shift_in = '0;
                     phase_in = PH_ST_CAP;
                  end else begin
                     phase_in = PH_DONE;
                  end
               end
            end
            PH_ST_CAP: begin
               shift_in = {shift_ff[39:0], b};
               if (13'(pos) == toff_ff + 13'd5) begin
                  rec.record_kind = KIND_STATION;
                  rec.address     = {shift_ff[39:0], b};
                  rec.item_index  = 12'(st_cnt_ff);
                  rec.item_offset = toff_ff[11:0];
                  emit      = 1'b1;
                  st_cnt_in = st_cnt_ff + 6'd1;
                  toff_in   = toff_ff + 13'd8;
                  phase_in  = PH_ST_WAIT;
               end
            end
            PH_AG_LOW: begin
               if (pos == nho_ff) begin
                  low_in   = b;
                  phase_in = PH_AG_HIGH;
               end
            end
            PH_AG_HIGH: begin
               if (agg_len == 12'd0) begin
                  toff_in  = 13'(nho_ff);
                  tval_in  = left > 15'sd2;
                  phase_in = PH_DONE;
               end else begin
                  sub_cnt_in = sub_cnt_ff + 12'd1;
                  rec.record_kind = KIND_SUBFRAME;
                  rec.item_index  = sub_cnt_ff + 12'd1;
                  rec.item_offset = nho_ff + 12'd2;
                  rec.item_length = (15'(agg_len) > body) ? body[11:0] : agg_len;
                  emit = 1'b1;
                  if (rem > 15'sd6) begin
                     nho_in   = nxt[11:0];
                     phase_in = PH_AG_LOW;
                  end else begin
                     tval_in  = rem > 15'sd2;
                     toff_in  = nxt;
                     phase_in = PH_DONE;
                  end
               end
            end
            default: ;
         endcase
         // trailing data on the last byte
         if (!emit && pos == len_cur - 12'd1 && tval_in && toff_in <= 13'(len_cur)) begin
            rec = '0;
            rec.record_kind = KIND_TRAILING;
            rec.item_offset = toff_in[11:0];
            rec.item_length = len_cur - toff_in[11:0];
            emit = 1'b1;
         end
      end
   end

   // hold a pending record until taken
   always_comb begin
      ovalid_in = ovalid_ff && !rsp.ready;
      odata_in  = odata_ff;
      if (accept && emit) begin
         ovalid_in = 1'b1;
         odata_in  = rec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= '0;
         len_ff     <= '0;
         phase_ff   <= PH_HEADER;
         st_cnt_ff  <= '0;
         sub_cnt_ff <= '0;
         nho_ff     <= '0;
         low_ff     <= '0;
         toff_ff    <= '0;
         shift_ff   <= '0;
         tval_ff    <= 1'b0;
         ovalid_ff  <= 1'b0;
      end else begin
         ovalid_ff <= ovalid_in;
         if (accept) begin
            pos_ff     <= pos_in;
            len_ff     <= len_in;
            phase_ff   <= phase_in;
            st_cnt_ff  <= st_cnt_in;
            sub_cnt_ff <= sub_cnt_in;
            nho_ff     <= nho_in;
            low_ff     <= low_in;
            toff_ff    <= toff_in;
            shift_ff   <= shift_in;
            tval_ff    <= tval_in;
         end
      end
   end

   // capture header bytes and the output record
   always_ff @(posedge clock) begin
      odata_ff <= odata_in;
      if (accept && (req.data.frame_start || phase_ff == PH_HEADER)
          && (req.data.frame_start ? 12'd0 : pos_ff) < 12'(HdrBytes)) begin
         hdr_ff[(req.data.frame_start ? 5'd0 : pos_ff[4:0])] <= b;
      end
   end

`ifndef SYNTH
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.data))
      else $error("pending record changed while stalled");
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp.valid |-> req.ready)
      else $error("input stalled with empty output");
   a_count: assert property (@(posedge clock) disable iff (reset)
      st_cnt_ff <= 6'(MaxStations))
      else $error("station count past limit");
`endif
endmodule

### sv/whap_header_decode.sv
// Header decode: builds the header record from the 20 header bytes.
module whap_header_decode import whap_pkg::*; (
   input  logic [7:0] hdr [HdrBytes],
   output rsp_type    rec
);
   logic [47:0] magic_field;
   logic        alt;

   always_comb begin
      magic_field = {hdr[8], hdr[9], hdr[10], hdr[11], hdr[12], hdr[13]};
      alt = (magic_field == Magic);
      rec = '0;
      rec.record_kind = KIND_HEADER;
      // classify the type byte
      priority if (hdr[0][3:0] == 4'h0) begin
         rec.packet_class = CLASS_BEACON;
      end else if (hdr[0] == 8'h11) begin
         rec.packet_class = CLASS_MGMT;
      end else if (hdr[0] == 8'h01) begin
         rec.packet_class = CLASS_DATA;
      end else begin
         rec.packet_class = CLASS_UNKNOWN;
      end
      rec.type_byte  = hdr[0];
      rec.mode_byte  = hdr[1];
      rec.alt_header = alt;
      // pick the field layout
      if (alt) begin
         rec.counter   = {hdr[5], hdr[6], hdr[7]};
         rec.address   = magic_field;
         rec.timestamp = {hdr[2], hdr[3], hdr[4]};
      end else begin
         rec.counter   = {8'h00, hdr[2], hdr[3]};
         rec.address   = {hdr[4], hdr[5], hdr[6], hdr[7], hdr[8], hdr[9]};
         rec.timestamp = {hdr[10], hdr[11], hdr[12]};
      end
      rec.ip_address = {hdr[16], hdr[17], hdr[18], hdr[19]};
   end
endmodule
